>>> sv/sgb_pkg.sv
`timescale 1ns / 1ps

package sgb_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int GLYPH_ROWS    = 9;

    localparam int ROM_ROWS    = 9;
    localparam int FIRST_CODE  = 32;
    localparam int LAST_CODE   = 90;
    localparam int NUM_GLYPHS  = LAST_CODE - FIRST_CODE + 1;
    localparam int DRAW_ROWS   = (GLYPH_ROWS < ROM_ROWS) ? GLYPH_ROWS : ROM_ROWS;
    localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;

    localparam int OP_W    = 2;
    localparam int CODE_W  = 8;
    localparam int POS_W   = 11;
    localparam int SCALE_W = 8;
    localparam int BYTE_W  = 8;
    localparam int ADV_W   = 11;
    localparam int COL_W   = POS_W + 1;
    localparam int YEND_W  = POS_W + 2;
    localparam int GBIT_W  = 4;

    localparam int ADDR_W     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int BYTE_IDX_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int ROW_W      = (DRAW_ROWS > 1) ? $clog2(DRAW_ROWS + 1) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_DRAW  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_RUN,
        ST_READ,
        ST_FINISH
    } state_t;

    localparam logic [8*ROM_ROWS-1:0] FONT_ROM [NUM_GLYPHS] = '{
        72'h000000000000000000, 72'h002020202020002000, 72'h005050000000000000,
        72'h005050F850F8505000, 72'h002078807008F02000, 72'h00C0C8102040981800,
        72'h0040A040A890680000, 72'h002020000000000000, 72'h001020404040201000,
        72'h004020101010204000, 72'h000020A870A8200000, 72'h00002020F820200000,
        72'h000000000020204000, 72'h00000000F800000000, 72'h000000000000200000,
        72'h000810102040408000, 72'h00708898A8C8887000, 72'h002060202020207000,
        72'h00708808304080F800, 72'h007088083008887000, 72'h0010305090F8101000,
        72'h00F880F00808887000, 72'h00304080F088887000, 72'h00F808102040404000,
        72'h007088887088887000, 72'h007088887808106000, 72'h000020000020000000,
        72'h000020000020204000, 72'h001020408040201000, 72'h000000F800F8000000,
        72'h004020100810204000, 72'h007088083020002000, 72'h007088B8A8B8807000,
        72'h0070888888F8888800, 72'h00F08888F08888F000, 72'h007088808080887000,
        72'h00F08888888888F000, 72'h00F88080F08080F800, 72'h00F88080F080808000,
        72'h00708880B888887000, 72'h00888888F888888800, 72'h007020202020207000,
        72'h003810101090906000, 72'h008890A0C0A0908800, 72'h00808080808080F800,
        72'h0088D8A88888888800, 72'h0088C8A89888888800, 72'h007088888888887000,
        72'h00F08888F080808000, 72'h0070888888A8906800, 72'h00F08888F0A0908800,
        72'h007088807008887000, 72'h00F820202020202000, 72'h008888888888887000,
        72'h008888885050202000, 72'h0088888888A8D88800, 72'h008850202050888800,
        72'h008888502020202000, 72'h00F80810204080F800
    };

    function automatic logic [BYTE_W-1:0] glyph_row(input logic [CODE_W-1:0] code,
                                                    input logic [ROW_W-1:0] row);
        logic [8*ROM_ROWS-1:0] bits;
        int                    idx;
        bits = '0;
        idx  = int'(code) - FIRST_CODE;
        if (idx >= 0 && idx < NUM_GLYPHS && int'(row) < ROM_ROWS)
        begin
            bits = FONT_ROM[idx];
            return bits[8*ROM_ROWS - 1 - 8*int'(row) -: 8];
        end
        return '0;
    endfunction

endpackage

>>> sv/sgb_cmd_if.sv
`timescale 1ns / 1ps

interface sgb_cmd_if;
    import sgb_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [CODE_W-1:0]  char_code;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [SCALE_W-1:0] scale;
    logic [POS_W-1:0]   rect_width;
    logic [POS_W-1:0]   rect_height;

    modport source (
        output valid, op, char_code, pos_x, pos_y, scale, rect_width, rect_height,
        input  ready
    );

    modport sink (
        input  valid, op, char_code, pos_x, pos_y, scale, rect_width, rect_height,
        output ready
    );
endinterface

>>> sv/sgb_rsp_if.sv
`timescale 1ns / 1ps

interface sgb_rsp_if;
    import sgb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic [ADV_W-1:0]  advance;

    modport source (
        output valid, read_byte, advance,
        input  ready
    );

    modport sink (
        input  valid, read_byte, advance,
        output ready
    );
endinterface

>>> sv/scaled_glyph_blitter.sv
`timescale 1ns / 1ps
// channel  dir  handshake      word
// cmd      in   valid/ready    op, char_code, pos_x, pos_y, scale, rect_width, rect_height
// rsp      out  valid/ready    read_byte, advance
//
// One frame store byte is read, modified and written back per cycle.
// Draw and clear step through the bytes touched in every clipped pixel row, then finish.
// Read passes through a read state before finishing; an item that changes nothing goes straight to finish.
// After reset all 38400 frame store bytes are swept to zero with cmd.ready low.
// A stalled rsp word holds; the next cmd word is taken while it waits.

module scaled_glyph_blitter (
    input logic        clk,
    input logic        rst_n,
    sgb_cmd_if.sink    cmd,
    sgb_rsp_if.source  rsp
);
    import sgb_pkg::*;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     wipe_addr_reg, wipe_addr_next;
    logic                  pend_reg, pend_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [BYTE_W-1:0]     read_byte_reg, read_byte_next;
    logic [ADV_W-1:0]      advance_reg, advance_next;

    logic [OP_W-1:0]       op_reg, op_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [SCALE_W-1:0]    scale_reg, scale_next;
    logic [POS_W-1:0]      x_reg, x_next;
    logic [COL_W-1:0]      xend_reg, xend_next;
    logic [POS_W-1:0]      py_reg, py_next;
    logic [POS_W-1:0]      py_last_reg, py_last_next;
    logic [ADDR_W-1:0]     row_base_reg, row_base_next;
    logic [BYTE_IDX_W-1:0] bi_reg, bi_next;
    logic [BYTE_IDX_W-1:0] first_b_reg, first_b_next;
    logic [BYTE_IDX_W-1:0] last_b_reg, last_b_next;
    logic [ROW_W-1:0]      grow_reg, grow_next;
    logic [SCALE_W-1:0]    sy_reg, sy_next;
    logic [SCALE_W-1:0]    sx_reg, sx_next;
    logic [GBIT_W-1:0]     gb_reg, gb_next;
    logic [ADDR_W-1:0]     waddr_reg, waddr_next;
    logic [BYTE_W-1:0]     mask_reg, mask_next;

    logic                  acc;
    logic                  x_ok, y_ok, code_ok;
    logic                  draw_go, clr_go, rd_go;
    logic [COL_W-1:0]      xsum, xend_in;
    logic [YEND_W-1:0]     ysum, yend_in;
    logic [ADDR_W-1:0]     row_start;

    logic [ADDR_W-1:0]     addr_cur;
    logic [BYTE_W-1:0]     row_bits;
    logic [BYTE_W-1:0]     win, pat;
    logic [GBIT_W-1:0]     gb_run;
    logic [SCALE_W-1:0]    sx_run;
    logic                  row_done, item_done;

    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [BYTE_W-1:0]     ram_wdata, ram_rdata;

    assign cmd.ready     = (state_reg == ST_IDLE);
    assign acc           = cmd.valid && cmd.ready;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_byte = read_byte_reg;
    assign rsp.advance   = advance_reg;

    // screen checks and clipped extents of the incoming word
    assign x_ok    = COL_W'(cmd.pos_x) < COL_W'(SCREEN_WIDTH);
    assign y_ok    = COL_W'(cmd.pos_y) < COL_W'(SCREEN_HEIGHT);
    assign code_ok = (cmd.char_code >= CODE_W'(FIRST_CODE))
                  && (cmd.char_code <= CODE_W'(LAST_CODE));
    assign draw_go = (cmd.op == OP_DRAW) && code_ok && x_ok && y_ok && (cmd.scale != '0);
    assign clr_go  = (cmd.op == OP_CLEAR) && x_ok && y_ok
                  && (cmd.rect_width != '0) && (cmd.rect_height != '0);
    assign rd_go   = (cmd.op == OP_READ) && x_ok && y_ok;

    assign xsum = (cmd.op == OP_DRAW)
                ? COL_W'(cmd.pos_x) + COL_W'({cmd.scale, 3'b000})
                : COL_W'(cmd.pos_x) + COL_W'(cmd.rect_width);
    assign xend_in = (xsum > COL_W'(SCREEN_WIDTH)) ? COL_W'(SCREEN_WIDTH) : xsum;

    assign ysum = (cmd.op == OP_DRAW)
                ? YEND_W'(cmd.pos_y) + YEND_W'(32'(cmd.scale) * DRAW_ROWS)
                : YEND_W'(cmd.pos_y) + YEND_W'(cmd.rect_height);
    assign yend_in = (ysum > YEND_W'(SCREEN_HEIGHT)) ? YEND_W'(SCREEN_HEIGHT) : ysum;

    assign row_start = ADDR_W'(32'(cmd.pos_y) * ROW_BYTES);

    assign addr_cur = row_base_reg + ADDR_W'(bi_reg);
    assign row_bits = glyph_row(code_reg, grow_reg);
    assign row_done  = (bi_reg == last_b_reg);
    assign item_done = row_done && (py_reg == py_last_reg);

    // pixel window of the current byte and the scaled glyph bits inside it
    always_comb
    begin
        logic [COL_W-1:0] col;
        win    = '0;
        pat    = '0;
        gb_run = gb_reg;
        sx_run = sx_reg;
        for (int k = 0; k < 8; k++)
        begin
            col = COL_W'({bi_reg, 3'b000}) + COL_W'(k);
            if ((col >= COL_W'(x_reg)) && (col < xend_reg))
            begin
                win[7-k] = 1'b1;
                pat[7-k] = row_bits[~gb_run[2:0]];
                if (sx_run == scale_reg - SCALE_W'(1))
                begin
                    sx_run = '0;
                    gb_run = gb_run + GBIT_W'(1);
                end
                else
                begin
                    sx_run = sx_run + SCALE_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wipe_addr_next = wipe_addr_reg;
        pend_next      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        read_byte_next = read_byte_reg;
        advance_next   = advance_reg;
        op_next        = op_reg;
        rd_ok_next     = rd_ok_reg;
        code_next      = code_reg;
        scale_next     = scale_reg;
        x_next         = x_reg;
        xend_next      = xend_reg;
        py_next        = py_reg;
        py_last_next   = py_last_reg;
        row_base_next  = row_base_reg;
        bi_next        = bi_reg;
        first_b_next   = first_b_reg;
        last_b_next    = last_b_reg;
        grow_next      = grow_reg;
        sy_next        = sy_reg;
        sx_next        = sx_reg;
        gb_next        = gb_reg;
        waddr_next     = waddr_reg;
        mask_next      = mask_reg;

        case (state_reg)
            ST_WIPE:
            begin
                wipe_addr_next = wipe_addr_reg + ADDR_W'(1);
                if (wipe_addr_reg == ADDR_W'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    op_next       = cmd.op;
                    rd_ok_next    = rd_go;
                    code_next     = cmd.char_code;
                    scale_next    = cmd.scale;
                    x_next        = cmd.pos_x;
                    xend_next     = xend_in;
                    py_next       = cmd.pos_y;
                    py_last_next  = POS_W'(yend_in - YEND_W'(1));
                    row_base_next = row_start;
                    first_b_next  = BYTE_IDX_W'(cmd.pos_x >> 3);
                    bi_next       = BYTE_IDX_W'(cmd.pos_x >> 3);
                    last_b_next   = BYTE_IDX_W'((xend_in - COL_W'(1)) >> 3);
                    grow_next     = '0;
                    sy_next       = '0;
                    sx_next       = '0;
                    gb_next       = '0;
                    if (draw_go || clr_go)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (rd_go)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_RUN:
            begin
                pend_next  = 1'b1;
                waddr_next = addr_cur;
                mask_next  = (op_reg == OP_DRAW) ? (win & pat) : win;
                if (!row_done)
                begin
                    bi_next = bi_reg + BYTE_IDX_W'(1);
                    gb_next = gb_run;
                    sx_next = sx_run;
                end
                else
                begin
                    bi_next       = first_b_reg;
                    gb_next       = '0;
                    sx_next       = '0;
                    py_next       = py_reg + POS_W'(1);
                    row_base_next = row_base_reg + ADDR_W'(ROW_BYTES);
                    if (sy_reg == scale_reg - SCALE_W'(1))
                    begin
                        sy_next   = '0;
                        grow_next = grow_reg + ROW_W'(1);
                    end
                    else
                    begin
                        sy_next = sy_reg + SCALE_W'(1);
                    end
                end
                if (item_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    read_byte_next = rd_ok_reg ? ram_rdata : '0;
                    advance_next   = ADV_W'({scale_reg, 3'b000});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_re    = (state_reg == ST_RUN) || (state_reg == ST_READ);
    assign ram_we    = (state_reg == ST_WIPE) || pend_reg;
    assign ram_waddr = (state_reg == ST_WIPE) ? wipe_addr_reg : waddr_reg;
    assign ram_wdata = (state_reg == ST_WIPE) ? '0
                     : (op_reg == OP_DRAW)    ? (ram_rdata | mask_reg)
                     :                          (ram_rdata & ~mask_reg);

    sgb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_cur),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            wipe_addr_reg <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wipe_addr_reg <= wipe_addr_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_byte_reg <= read_byte_next;
        advance_reg   <= advance_next;
        op_reg        <= op_next;
        rd_ok_reg     <= rd_ok_next;
        code_reg      <= code_next;
        scale_reg     <= scale_next;
        x_reg         <= x_next;
        xend_reg      <= xend_next;
        py_reg        <= py_next;
        py_last_reg   <= py_last_next;
        row_base_reg  <= row_base_next;
        bi_reg        <= bi_next;
        first_b_reg   <= first_b_next;
        last_b_reg    <= last_b_next;
        grow_reg      <= grow_next;
        sy_reg        <= sy_next;
        sx_reg        <= sx_next;
        gb_reg        <= gb_next;
        waddr_reg     <= waddr_next;
        mask_reg      <= mask_next;
    end
endmodule

>>> sv/sgb_ram.sv
`timescale 1ns / 1ps

module sgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> sv/sgb_checker.sv
`timescale 1ns / 1ps

module sgb_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cmd_valid,
    input logic                      cmd_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [sgb_pkg::BYTE_W-1:0] rsp_read_byte,
    input logic [sgb_pkg::ADV_W-1:0]  rsp_advance
);
    // stalled word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte)
                                    && $stable(rsp_advance))
        else $error("rsp word changed while stalled");

    // one word in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("cmd taken while previous word still in work");

    // cmd held off at the start of the frame store sweep
    a_wipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !cmd_ready)
        else $error("cmd ready during frame store sweep");

    a_adv_mult: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_advance[2:0] == 3'b000)
        else $error("advance not a multiple of eight");
endmodule

bind scaled_glyph_blitter sgb_checker u_sgb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_byte (rsp.read_byte),
    .rsp_advance   (rsp.advance)
);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import sgb_pkg::*;

    localparam int TABLE_ROWS = 9;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic [71:0] glyph_table [0:58] = '{
        72'h000000000000000000, 72'h002020202020002000, 72'h005050000000000000,
        72'h005050F850F8505000, 72'h002078807008F02000, 72'h00C0C8102040981800,
        72'h0040A040A890680000, 72'h002020000000000000, 72'h001020404040201000,
        72'h004020101010204000, 72'h000020A870A8200000, 72'h00002020F820200000,
        72'h000000000020204000, 72'h00000000F800000000, 72'h000000000000200000,
        72'h000810102040408000, 72'h00708898A8C8887000, 72'h002060202020207000,
        72'h00708808304080F800, 72'h007088083008887000, 72'h0010305090F8101000,
        72'h00F880F00808887000, 72'h00304080F088887000, 72'h00F808102040404000,
        72'h007088887088887000, 72'h007088887808106000, 72'h000020000020000000,
        72'h000020000020204000, 72'h001020408040201000, 72'h000000F800F8000000,
        72'h004020100810204000, 72'h007088083020002000, 72'h007088B8A8B8807000,
        72'h0070888888F8888800, 72'h00F08888F08888F000, 72'h007088808080887000,
        72'h00F08888888888F000, 72'h00F88080F08080F800, 72'h00F88080F080808000,
        72'h00708880B888887000, 72'h00888888F888888800, 72'h007020202020207000,
        72'h003810101090906000, 72'h008890A0C0A0908800, 72'h00808080808080F800,
        72'h0088D8A88888888800, 72'h0088C8A89888888800, 72'h007088888888887000,
        72'h00F08888F080808000, 72'h0070888888A8906800, 72'h00F08888F0A0908800,
        72'h007088807008887000, 72'h00F820202020202000, 72'h008888888888887000,
        72'h008888885050202000, 72'h0088888888A8D88800, 72'h008850202050888800,
        72'h008888502020202000, 72'h00F80810204080F800
    };

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CODE_W-1:0]  char_code;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [SCALE_W-1:0] scale;
        logic [POS_W-1:0]   rect_width;
        logic [POS_W-1:0]   rect_height;
    } blit_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [ADV_W-1:0]  advance;
    } blit_rsp_t;

    typedef struct {
        int x;
        int y;
        int s;
    } glyph_mark_t;

    logic clk = 1'b0;
    logic rst_n;

    sgb_cmd_if cmd ();
    sgb_rsp_if rsp ();

    scaled_glyph_blitter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    bit [7:0]    screen_bytes [STORE_BYTES];
    blit_cmd_t   pending_q [$];
    blit_rsp_t   expected_q [$];
    glyph_mark_t recent_marks [$];
    blit_cmd_t   live_cmd;
    blit_rsp_t   want;
    int          sent_count = 0;
    int          got_count = 0;
    int          send_gap = 0;
    int          pause_left = 0;
    int          hold_left = 0;
    bit          hold_fired = 1'b0;
    int          errors = 0;

    always #2 clk = ~clk;

    function automatic int pick_gap(int count, int quiet_slot);
        if ((count / 100) % 4 == quiet_slot)
            return 0;
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic blit_rsp_t apply_command(blit_cmd_t c);
        blit_rsp_t   r;
        int          x;
        int          y;
        int          s;
        int          px;
        int          py;
        int          row;
        int          sy;
        int          b;
        int          sx;
        logic [71:0] glyph;
        logic [7:0]  row_bits;
        x = int'(c.pos_x);
        y = int'(c.pos_y);
        s = int'(c.scale);
        r.read_byte = '0;
        r.advance   = ADV_W'(8 * s);
        if (c.op == OP_DRAW)
        begin
            if (int'(c.char_code) >= FIRST_CODE && int'(c.char_code) <= LAST_CODE &&
                x < SCREEN_WIDTH && y < SCREEN_HEIGHT && s != 0)
            begin
                glyph = glyph_table[int'(c.char_code) - FIRST_CODE];
                for (row = 0; row < GLYPH_ROWS && row < TABLE_ROWS; row++)
                begin
                    row_bits = glyph[71 - 8 * row -: 8];
                    for (sy = 0; sy < s && y + row * s + sy < SCREEN_HEIGHT; sy++)
                    begin
                        py = y + row * s + sy;
                        for (b = 0; b < 8; b++)
                        begin
                            if (row_bits[7 - b])
                            begin
                                for (sx = 0; sx < s && x + b * s + sx < SCREEN_WIDTH; sx++)
                                begin
                                    px = x + b * s + sx;
                                    screen_bytes[py * ROW_BYTES + px / 8] |= 8'h80 >> (px % 8);
                                end
                            end
                        end
                    end
                end
            end
        end
        else if (c.op == OP_CLEAR)
        begin
            for (py = y; py < y + int'(c.rect_height) && py < SCREEN_HEIGHT; py++)
                for (px = x; px < x + int'(c.rect_width) && px < SCREEN_WIDTH; px++)
                    screen_bytes[py * ROW_BYTES + px / 8] &= ~(8'h80 >> (px % 8));
        end
        else if (c.op == OP_READ)
        begin
            if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT)
                r.read_byte = screen_bytes[y * ROW_BYTES + x / 8];
        end
        return r;
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input int code, input int x,
                             input int y, input int s, input int w, input int h);
        blit_cmd_t   c;
        glyph_mark_t m;
        c.op          = op;
        c.char_code   = CODE_W'(code);
        c.pos_x       = POS_W'(x);
        c.pos_y       = POS_W'(y);
        c.scale       = SCALE_W'(s);
        c.rect_width  = POS_W'(w);
        c.rect_height = POS_W'(h);
        pending_q.push_back(c);
        if (op == OP_DRAW && x < SCREEN_WIDTH && y < SCREEN_HEIGHT && s != 0)
        begin
            m.x = x;
            m.y = y;
            m.s = s;
            recent_marks.push_back(m);
            if (recent_marks.size() > 16)
                void'(recent_marks.pop_front());
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                expected_q.push_back(apply_command(live_cmd));
                sent_count++;
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd.valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    live_cmd = pending_q.pop_front();
                    cmd.op          <= live_cmd.op;
                    cmd.char_code   <= live_cmd.char_code;
                    cmd.pos_x       <= live_cmd.pos_x;
                    cmd.pos_y       <= live_cmd.pos_y;
                    cmd.scale       <= live_cmd.scale;
                    cmd.rect_width  <= live_cmd.rect_width;
                    cmd.rect_height <= live_cmd.rect_height;
                    cmd.valid       <= 1'b1;
                    send_gap = pick_gap(sent_count, 1);
                end
                else
                begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end
        else if (!hold_fired && got_count >= 150)
        begin
            hold_left  <= 600;
            hold_fired <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            pause_left = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors < 100)
                        $display("%0t: unexpected word read_byte %02h advance %0d",
                                 $time, rsp.read_byte, rsp.advance);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.read_byte !== want.read_byte)
                    begin
                        errors++;
                        if (errors < 100)
                            $display("%0t: read_byte expected %02h got %02h",
                                     $time, want.read_byte, rsp.read_byte);
                    end
                    if (rsp.advance !== want.advance)
                    begin
                        errors++;
                        if (errors < 100)
                            $display("%0t: advance expected %0d got %0d",
                                     $time, want.advance, rsp.advance);
                    end
                end
                got_count <= got_count + 1;
                pause_left = pick_gap(got_count, 2);
            end
            if (hold_left != 0 || pause_left != 0)
            begin
                rsp.ready <= 1'b0;
                if (pause_left != 0)
                    pause_left--;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int               n;
        int               pick;
        int               mid_left;
        int               big_left;
        int               total;
        logic [OP_W-1:0]  op;
        int               code;
        int               x;
        int               y;
        int               s;
        int               w;
        int               h;
        glyph_mark_t      m;
        rst_n           = 1'b0;
        cmd.valid       = 1'b0;
        cmd.op          = '0;
        cmd.char_code   = '0;
        cmd.pos_x       = '0;
        cmd.pos_y       = '0;
        cmd.scale       = '0;
        cmd.rect_width  = '0;
        cmd.rect_height = '0;
        rsp.ready       = 1'b0;

        queue_cmd(OP_READ, 0, 0, 0, 0, 0, 0);
        queue_cmd(OP_DRAW, 65, 0, 0, 1, 0, 0);
        queue_cmd(OP_READ, 0, 0, 1, 1, 0, 0);
        queue_cmd(OP_READ, 0, 7, 5, 1, 0, 0);
        queue_cmd(OP_DRAW, 31, 100, 100, 1, 0, 0);
        queue_cmd(OP_DRAW, 91, 100, 100, 1, 0, 0);
        queue_cmd(OP_DRAW, 255, 100, 100, 2, 2047, 2047);
        queue_cmd(OP_DRAW, 32, 100, 100, 1, 0, 0);
        queue_cmd(OP_READ, 0, 100, 102, 0, 0, 0);
        queue_cmd(OP_DRAW, 90, 8, 0, 1, 0, 0);
        queue_cmd(OP_DRAW, 72, 640, 0, 1, 0, 0);
        queue_cmd(OP_DRAW, 72, 0, 480, 1, 0, 0);
        queue_cmd(OP_DRAW, 72, 2047, 2047, 255, 0, 0);
        queue_cmd(OP_DRAW, 72, 200, 200, 0, 0, 0);
        queue_cmd(OP_READ, 0, 200, 201, 0, 0, 0);
        queue_cmd(OP_DRAW, 35, 636, 472, 2, 0, 0);
        queue_cmd(OP_READ, 0, 639, 475, 0, 0, 0);
        queue_cmd(OP_DRAW, 87, 639, 479, 255, 0, 0);
        queue_cmd(OP_DRAW, 56, 10, 10, 60, 0, 0);
        queue_cmd(OP_READ, 0, 300, 100, 0, 0, 0);
        queue_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 5);
        queue_cmd(OP_CLEAR, 0, 0, 0, 0, 5, 0);
        queue_cmd(OP_CLEAR, 0, 640, 0, 0, 100, 100);
        queue_cmd(OP_CLEAR, 0, 0, 480, 0, 100, 100);
        queue_cmd(OP_CLEAR, 0, 630, 470, 0, 2047, 2047);
        queue_cmd(OP_READ, 0, 639, 479, 0, 0, 0);
        queue_cmd(OP_CLEAR, 0, 0, 0, 0, 2047, 2047);
        queue_cmd(OP_READ, 0, 300, 100, 0, 0, 0);
        queue_cmd(OP_READ, 0, 640, 0, 0, 0, 0);
        queue_cmd(OP_READ, 0, 0, 480, 0, 0, 0);
        queue_cmd(OP_SPARE, 255, 2047, 2047, 255, 2047, 2047);

        mid_left = 100;
        big_left = 6;
        for (n = 0; n < 800; n++)
        begin
            pick = $urandom_range(0, 99);
            op   = OP_DRAW;
            code = $urandom_range(FIRST_CODE, LAST_CODE);
            s    = $urandom_range(1, 3);
            x    = $urandom_range(0, 1) ? $urandom_range(0, SCREEN_WIDTH - 1)
                                        : $urandom_range(SCREEN_WIDTH - 24, SCREEN_WIDTH - 1);
            y    = $urandom_range(0, 1) ? $urandom_range(0, SCREEN_HEIGHT - 1)
                                        : $urandom_range(SCREEN_HEIGHT - 28, SCREEN_HEIGHT - 1);
            w    = $urandom_range(0, 2047);
            h    = $urandom_range(0, 2047);
            if (pick < 55)
            begin
                if ($urandom_range(0, 9) == 0)
                    code = $urandom_range(0, 255);
            end
            else if (pick < 70)
            begin
                op = OP_READ;
                if (recent_marks.size() != 0 && $urandom_range(0, 9) < 7)
                begin
                    m = recent_marks[$urandom_range(0, recent_marks.size() - 1)];
                    x = m.x + $urandom_range(0, 8 * m.s + 7);
                    y = m.y + $urandom_range(0, 9 * m.s);
                    if (x > 2047)
                        x = 2047;
                    if (y > 2047)
                        y = 2047;
                end
            end
            else if (pick < 80)
            begin
                op = OP_CLEAR;
                w  = $urandom_range(0, 40);
                h  = $urandom_range(0, 40);
            end
            else if (pick < 90)
            begin
                op   = OP_W'($urandom_range(0, 3));
                code = $urandom_range(0, 255);
                x    = $urandom_range(0, 2047);
                y    = $urandom_range(0, 2047);
                s    = $urandom_range(0, 255);
                // keep full-range noise cheap: push any real work off-screen
                if ((op == OP_CLEAR || (op == OP_DRAW && code >= FIRST_CODE &&
                     code <= LAST_CODE && s != 0)) && y < SCREEN_HEIGHT)
                    x = $urandom_range(SCREEN_WIDTH, 2047);
            end
            else if (pick < 98 && mid_left > 0)
            begin
                mid_left--;
                if ($urandom_range(0, 1) == 0)
                begin
                    s = $urandom_range(4, 12);
                end
                else
                begin
                    op = OP_CLEAR;
                    w  = $urandom_range(41, 120);
                    h  = $urandom_range(41, 120);
                end
            end
            else if (pick >= 98 && big_left > 0)
            begin
                big_left--;
                x = $urandom_range(0, SCREEN_WIDTH - 1);
                y = $urandom_range(0, SCREEN_HEIGHT - 1);
                if ($urandom_range(0, 1) == 0)
                begin
                    s = $urandom_range(13, 255);
                end
                else
                begin
                    op = OP_CLEAR;
                    w  = $urandom_range(121, 2047);
                    h  = $urandom_range(121, 2047);
                end
            end
            queue_cmd(op, code, x, y, s, w, h);
        end
        total = pending_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (got_count < total)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
